@@ rtl/core/rrts_pkg.sv @@
`default_nettype none

package rrts_pkg;

   localparam int MAX_TASKS = 16;
   localparam int SLOT_W    = $clog2(MAX_TASKS);
   localparam int USED_W    = $clog2(MAX_TASKS + 1);
   // wide enough for any slot number or slot count in the allowed range
   localparam int WIDE_W    = 9;

   typedef logic [1:0]        slot_state_type;
   typedef logic [1:0]        opcode_type;
   typedef logic [SLOT_W-1:0] slot_type;
   typedef logic [USED_W-1:0] count_type;

   localparam slot_state_type ST_EMPTY   = 2'd0;
   localparam slot_state_type ST_READY   = 2'd1;
   localparam slot_state_type ST_RUNNING = 2'd2;
   localparam slot_state_type ST_DEAD    = 2'd3;

   localparam opcode_type OP_SPAWN = 2'd0;
   localparam opcode_type OP_YIELD = 2'd1;
   localparam opcode_type OP_EXIT  = 2'd2;
   localparam opcode_type OP_KILL  = 2'd3;

   // slot numbers leave the block as 4 bits
   function automatic logic [3:0] slot_to_out(input slot_type s);
      logic [WIDE_W-1:0] w;
      w = WIDE_W'(s);
      return w[3:0];
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/round_robin_task_scheduler.sv @@
// Round-robin task scheduler over a table of task slots.
// Request channel (req_valid/req_stall): one operation per transfer, opcode
// spawn, yield, exit or kill, plus the slot to kill.
// Response channel (rsp_valid/rsp_stall): exactly one result per request, in
// order: status, spawned id, switch flag, previous and running slot, halted.
// Slot states live in a one-port-read, one-port-write RAM with a registered
// read; the scheduler walks it with a small sequencer, one request at a time.
// Each request passes through S_EXEC; spawn and kill then go to S_DONE.
// Yield and exit first scan in S_SCAN, reading slots until a ready task is
// found (at most the number of slots handed out), the pipelined scan issuing
// one RAM read per cycle. A switch then passes through S_FIX to write back
// the old task's state on the single write port, then goes to S_DONE.
// A new request is taken as soon as the previous result sits in the
// response register; if the response is stalled, a finished result waits
// in the sequencer until the register frees up.
// Reset (synchronous) sets slot 0 running, hands out no other slots and
// empties the response register.
`default_nettype none

module round_robin_task_scheduler
   import rrts_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_stall,
   input  wire logic [1:0] req_opcode,
   input  wire logic [3:0] req_target_slot,
   output      logic       rsp_valid,
   input  wire logic       rsp_stall,
   output      logic       rsp_status,
   output      logic [3:0] rsp_spawned_id,
   output      logic       rsp_switched,
   output      logic [3:0] rsp_previous_slot,
   output      logic [3:0] rsp_running_slot,
   output      logic       rsp_halted
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_SCAN = 3'd2;
   localparam logic [2:0] S_FIX  = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0]  state_ff, state_in;
   opcode_type  op_ff, op_in;
   logic [3:0]  target_ff, target_in;
   slot_type    cur_ff, cur_in;
   count_type   used_ff, used_in;
   logic        cur_dead_ff, cur_dead_in;
   logic        old_dead_ff, old_dead_in;
   slot_type    prev_ff, prev_in;
   logic        status_ff, status_in;
   slot_type    spawned_ff, spawned_in;
   logic        switched_ff, switched_in;
   slot_type    rd_idx_ff, rd_idx_in;
   count_type   rd_cnt_ff, rd_cnt_in;
   logic        chk_valid_ff, chk_valid_in;
   slot_type    chk_idx_ff, chk_idx_in;
   logic        chk_last_ff, chk_last_in;

   logic        rsp_valid_ff;
   logic        rsp_status_ff;
   slot_type    rsp_spawned_ff;
   logic        rsp_switched_ff;
   slot_type    rsp_prev_ff;
   slot_type    rsp_run_ff;
   logic        rsp_halted_ff;
   logic        rsp_load;

   logic           ram_wr_en;
   slot_type       ram_wr_addr;
   slot_state_type ram_wr_data;
   logic           ram_rd_en;
   slot_type       ram_rd_addr;
   slot_state_type ram_rd_data;

   logic [WIDE_W-1:0] last_w;
   logic [WIDE_W-1:0] tgt_w;
   slot_type          start_idx;
   slot_type          rd_next;

   rrts_slot_ram u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // round-robin successor within the used slots
   assign last_w    = WIDE_W'(used_ff) - WIDE_W'(1);
   assign tgt_w     = WIDE_W'(target_ff);
   assign start_idx = (WIDE_W'(cur_ff) == last_w) ? '0 : SLOT_W'(cur_ff + 1'b1);
   assign rd_next   = (WIDE_W'(rd_idx_ff) == last_w) ? '0 : SLOT_W'(rd_idx_ff + 1'b1);

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_load  = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      target_in    = target_ff;
      cur_in       = cur_ff;
      used_in      = used_ff;
      cur_dead_in  = cur_dead_ff;
      old_dead_in  = old_dead_ff;
      prev_in      = prev_ff;
      status_in    = status_ff;
      spawned_in   = spawned_ff;
      switched_in  = switched_ff;
      rd_idx_in    = rd_idx_ff;
      rd_cnt_in    = rd_cnt_ff;
      chk_valid_in = chk_valid_ff;
      chk_idx_in   = chk_idx_ff;
      chk_last_in  = chk_last_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = cur_ff;
      ram_wr_data  = ST_DEAD;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = rd_idx_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in       = req_opcode;
               target_in   = req_target_slot;
               prev_in     = cur_ff;
               status_in   = 1'b0;
               spawned_in  = '0;
               switched_in = 1'b0;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            rd_idx_in    = start_idx;
            rd_cnt_in    = '0;
            chk_valid_in = 1'b0;
            unique case (op_ff)
               OP_SPAWN: begin
                  if (used_ff == USED_W'(MAX_TASKS)) begin
                     status_in = 1'b1;
                  end else begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = used_ff[SLOT_W-1:0];
                     ram_wr_data = ST_READY;
                     spawned_in  = used_ff[SLOT_W-1:0];
                     used_in     = USED_W'(used_ff + 1'b1);
                  end
                  state_in = S_DONE;
               end
               OP_KILL: begin
                  if (tgt_w == WIDE_W'(cur_ff) || tgt_w >= WIDE_W'(used_ff)) begin
                     status_in = 1'b1;
                  end else begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = tgt_w[SLOT_W-1:0];
                     ram_wr_data = ST_DEAD;
                  end
                  state_in = S_DONE;
               end
               OP_EXIT: begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = cur_ff;
                  ram_wr_data = ST_DEAD;
                  cur_dead_in = 1'b1;
                  state_in    = S_SCAN;
               end
               OP_YIELD: begin
                  state_in = S_SCAN;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_SCAN: begin
            // read one slot per cycle, check its data in the cycle after
            if (rd_cnt_ff != used_ff) begin
               ram_rd_en    = 1'b1;
               rd_idx_in    = rd_next;
               rd_cnt_in    = USED_W'(rd_cnt_ff + 1'b1);
               chk_valid_in = 1'b1;
               chk_idx_in   = rd_idx_ff;
               chk_last_in  = (USED_W'(rd_cnt_ff + 1'b1) == used_ff);
            end else begin
               chk_valid_in = 1'b0;
            end
            if (chk_valid_ff) begin
               if (ram_rd_data == ST_READY) begin
                  if (chk_idx_ff == cur_ff) begin
                     state_in = S_DONE;
                  end else begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = chk_idx_ff;
                     ram_wr_data = ST_RUNNING;
                     old_dead_in = cur_dead_ff;
                     cur_dead_in = 1'b0;
                     cur_in      = chk_idx_ff;
                     switched_in = 1'b1;
                     state_in    = S_FIX;
                  end
               end else if (chk_last_ff) begin
                  state_in = S_DONE;
               end
            end
         end
         S_FIX: begin
            // old task goes back to ready unless it exited
            if (!old_dead_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = prev_ff;
               ram_wr_data = ST_READY;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (reset) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = '0;
         ram_wr_data = ST_RUNNING;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_ff       <= '0;
         used_ff      <= USED_W'(1);
         cur_dead_ff  <= 1'b0;
         chk_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         used_ff      <= used_in;
         cur_dead_ff  <= cur_dead_in;
         chk_valid_ff <= chk_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      target_ff   <= target_in;
      old_dead_ff <= old_dead_in;
      prev_ff     <= prev_in;
      status_ff   <= status_in;
      spawned_ff  <= spawned_in;
      switched_ff <= switched_in;
      rd_idx_ff   <= rd_idx_in;
      rd_cnt_ff   <= rd_cnt_in;
      chk_idx_ff  <= chk_idx_in;
      chk_last_ff <= chk_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff   <= status_ff;
         rsp_spawned_ff  <= spawned_ff;
         rsp_switched_ff <= switched_ff;
         rsp_prev_ff     <= prev_ff;
         rsp_run_ff      <= cur_ff;
         rsp_halted_ff   <= cur_dead_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_spawned_id    = slot_to_out(rsp_spawned_ff);
   assign rsp_switched      = rsp_switched_ff;
   assign rsp_previous_slot = slot_to_out(rsp_prev_ff);
   assign rsp_running_slot  = slot_to_out(rsp_run_ff);
   assign rsp_halted        = rsp_halted_ff;

endmodule

`default_nettype wire

@@ rtl/core/rrts_slot_ram.sv @@
`default_nettype none

module rrts_slot_ram
   import rrts_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           wr_en,
   input  wire slot_type       wr_addr,
   input  wire slot_state_type wr_data,
   input  wire logic           rd_en,
   input  wire slot_type       rd_addr,
   output      slot_state_type rd_data
);

   slot_state_type mem [MAX_TASKS];
   slot_state_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/core/rrts_checker.sv @@
`default_nettype none

module rrts_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic [1:0] req_opcode,
   input wire logic [3:0] req_target_slot,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic       rsp_status,
   input wire logic [3:0] rsp_spawned_id,
   input wire logic       rsp_switched,
   input wire logic [3:0] rsp_previous_slot,
   input wire logic [3:0] rsp_running_slot,
   input wire logic       rsp_halted
);

   // held response stays up until the transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a switch moves to another slot, no switch keeps the slot
   a_switch_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_switched == (rsp_previous_slot != rsp_running_slot)))
      else $error("switch flag disagrees with slots");

   a_error_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> !rsp_switched && rsp_spawned_id == 4'd0)
      else $error("error response with side effects");

   a_switch_live: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_switched |-> !rsp_halted)
      else $error("switched to a dead task");

endmodule

bind round_robin_task_scheduler rrts_checker u_rrts_checker (.*);

`default_nettype wire

@@ tb/round_robin_task_scheduler_test.sv @@
`timescale 1ns / 100ps

module round_robin_task_scheduler_test;
   import rrts_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_SHAPED = 1150;
   localparam int RANDOM_NOISE  = 100;
   localparam int DRAIN_CYCLES  = 30;
   localparam int N_DIRECTED    = 20;

   typedef struct packed {
      logic       status;
      logic [3:0] spawned_id;
      logic       switched;
      logic [3:0] previous_slot;
      logic [3:0] running_slot;
      logic       halted;
   } sched_result_type;

   typedef struct packed {
      opcode_type       op;
      logic [3:0]       tgt;
      logic [4:0]       reps;
      logic             has_literal;
      sched_result_type want;
   } step_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_opcode = OP_YIELD;
   logic [3:0] req_target_slot = 4'd0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_status;
   logic [3:0] rsp_spawned_id;
   logic       rsp_switched;
   logic [3:0] rsp_previous_slot;
   logic [3:0] rsp_running_slot;
   logic       rsp_halted;

   // scheduler shadow state
   slot_state_type task_state [MAX_TASKS];
   count_type      tasks_handed;
   slot_type       cur_task;

   sched_result_type pending_results [$];
   step_row_type     directed_steps [N_DIRECTED];
   int               error_count = 0;
   int               cycle_count = 0;
   int               burst_left = 0;
   int               stall_mode = 0;

   round_robin_task_scheduler u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_target_slot   (req_target_slot),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_spawned_id    (rsp_spawned_id),
      .rsp_switched      (rsp_switched),
      .rsp_previous_slot (rsp_previous_slot),
      .rsp_running_slot  (rsp_running_slot),
      .rsp_halted        (rsp_halted)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // round-robin scan over handed-out slots, ending at the current one
   function automatic bit rotate_to_ready();
      int unsigned idx;
      for (int unsigned i = 1; i <= tasks_handed; i++) begin
         idx = (int'(cur_task) + i) % int'(tasks_handed);
         if (task_state[idx] == ST_READY) begin
            if (idx == cur_task) return 1'b0;
            if (task_state[cur_task] == ST_RUNNING) task_state[cur_task] = ST_READY;
            task_state[idx] = ST_RUNNING;
            cur_task = slot_type'(idx);
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic sched_result_type schedule_step(input opcode_type op,
                                                      input logic [3:0] tgt);
      sched_result_type r;
      r = '0;
      r.previous_slot = cur_task;
      case (op)
         OP_SPAWN: begin
            if (int'(tasks_handed) >= MAX_TASKS) begin
               r.status = 1'b1;
            end else begin
               r.spawned_id = tasks_handed[3:0];
               task_state[tasks_handed[SLOT_W-1:0]] = ST_READY;
               tasks_handed = tasks_handed + 1'b1;
            end
         end
         OP_YIELD: begin
            r.switched = rotate_to_ready();
         end
         OP_EXIT: begin
            task_state[cur_task] = ST_DEAD;
            r.switched = rotate_to_ready();
         end
         default: begin
            if (tgt == cur_task || int'(tgt) >= int'(tasks_handed)) r.status = 1'b1;
            else task_state[tgt] = ST_DEAD;
         end
      endcase
      r.running_slot = cur_task;
      r.halted = (task_state[cur_task] == ST_DEAD);
      return r;
   endfunction

   // one request transfer; the sender may idle between bursts
   task automatic issue(input opcode_type op, input logic [3:0] tgt, input bit has_literal,
                        input sched_result_type want);
      int gap;
      sched_result_type predicted;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_opcode <= op;
      req_target_slot <= tgt;
      do @(posedge clock); while (req_stall);
      predicted = schedule_step(op, tgt);
      pending_results.push_back(has_literal ? want : predicted);
   endtask

   task automatic check_field(input string name, input logic [3:0] want, input logic [3:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      sched_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response transfer, expected none, actual slot %0d",
                     $time, rsp_running_slot);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("status", 4'(want.status), 4'(rsp_status));
            check_field("spawned_id", want.spawned_id, rsp_spawned_id);
            check_field("switched", 4'(want.switched), 4'(rsp_switched));
            check_field("previous_slot", want.previous_slot, rsp_previous_slot);
            check_field("running_slot", want.running_slot, rsp_running_slot);
            check_field("halted", 4'(want.halted), 4'(rsp_halted));
         end
      end
   end

   // receiver backpressure in one of four randomly picked stall modes
   always @(posedge clock) begin
      if (cycle_count % 64 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= 1'($urandom_range(0, 1));
         2: rsp_stall <= (cycle_count % 3 == 0);
         default: rsp_stall <= ($urandom_range(0, 7) != 0);
      endcase
   end

   initial begin
      int pick;
      opcode_type op;
      for (int i = 0; i < MAX_TASKS; i++) task_state[i] = ST_EMPTY;
      task_state[0] = ST_RUNNING;
      tasks_handed = count_type'(1);
      cur_task = '0;

      directed_steps = '{
         '{OP_YIELD, 4'd0,  5'd1,  1'b1, '{1'b0, 4'd0, 1'b0, 4'd0, 4'd0, 1'b0}},
         '{OP_KILL,  4'd0,  5'd1,  1'b1, '{1'b1, 4'd0, 1'b0, 4'd0, 4'd0, 1'b0}},
         '{OP_KILL,  4'd15, 5'd1,  1'b1, '{1'b1, 4'd0, 1'b0, 4'd0, 4'd0, 1'b0}},
         '{OP_SPAWN, 4'd0,  5'd1,  1'b1, '{1'b0, 4'd1, 1'b0, 4'd0, 4'd0, 1'b0}},
         '{OP_YIELD, 4'd0,  5'd1,  1'b1, '{1'b0, 4'd0, 1'b1, 4'd0, 4'd1, 1'b0}},
         '{OP_SPAWN, 4'd9,  5'd1,  1'b1, '{1'b0, 4'd2, 1'b0, 4'd1, 4'd1, 1'b0}},
         '{OP_KILL,  4'd0,  5'd1,  1'b0, '0},  // kill a ready task
         '{OP_KILL,  4'd0,  5'd1,  1'b0, '0},  // kill an already dead task
         '{OP_YIELD, 4'd0,  5'd1,  1'b0, '0},
         '{OP_EXIT,  4'd0,  5'd1,  1'b0, '0},
         '{OP_EXIT,  4'd0,  5'd1,  1'b0, '0},  // nothing ready: halts
         '{OP_YIELD, 4'd0,  5'd1,  1'b0, '0},
         '{OP_EXIT,  4'd0,  5'd1,  1'b0, '0},  // exit of dead current
         '{OP_SPAWN, 4'd0,  5'd1,  1'b0, '0},
         '{OP_YIELD, 4'd0,  5'd1,  1'b0, '0},  // leaves the halt
         '{OP_KILL,  4'd3,  5'd1,  1'b1, '{1'b1, 4'd0, 1'b0, 4'd3, 4'd3, 1'b0}},
         '{OP_SPAWN, 4'd6,  5'd12, 1'b0, '0},
         '{OP_SPAWN, 4'd0,  5'd1,  1'b1, '{1'b1, 4'd0, 1'b0, 4'd3, 4'd3, 1'b0}},
         '{OP_KILL,  4'd15, 5'd1,  1'b0, '0},
         '{OP_EXIT,  4'd0,  5'd1,  1'b0, '0}
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_steps[i]) begin
         for (int k = 0; k < directed_steps[i].reps; k++) begin
            issue(directed_steps[i].op, directed_steps[i].tgt,
                  directed_steps[i].has_literal, directed_steps[i].want);
         end
      end

      // mostly yields so that live tasks wear down slowly
      for (int n = 0; n < RANDOM_SHAPED; n++) begin
         pick = $urandom_range(0, 199);
         if (pick < 2) op = OP_EXIT;
         else if (pick < 4) op = OP_KILL;
         else if (pick < 14) op = OP_SPAWN;
         else op = OP_YIELD;
         issue(op, 4'($urandom_range(0, 15)), 1'b0, '0);
      end
      for (int n = 0; n < RANDOM_NOISE; n++) begin
         issue(opcode_type'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), 1'b0, '0);
      end
      req_valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
